// File: hdl/sacache_pkg.sv
package sacache_pkg;

	localparam int unsigned WaysDefault = 4;
	localparam int unsigned SetsDefault = 256;
	localparam int unsigned AddrBitsDefault = 32;
	localparam int unsigned CntW = 32;

	// event counter slots
	localparam int unsigned CntAcc = 0;
	localparam int unsigned CntRd = 1;
	localparam int unsigned CntWr = 2;
	localparam int unsigned CntHit = 3;
	localparam int unsigned CntMiss = 4;
	localparam int unsigned CntFetch = 5;
	localparam int unsigned CntWb = 6;
	localparam int unsigned CntNum = 7;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_FLUSH = 2'd2,
		REQ_NONE  = 2'd3
	} req_e;

	localparam logic POL_FIFO = 1'b0;
	localparam logic POL_LRU = 1'b1;

	localparam int unsigned RegPolicy = 0;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] blk_addr;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        refill;
		logic        writeback;
		logic [31:0] access_count;
		logic [31:0] read_count;
		logic [31:0] write_count;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic [31:0] fetch_count;
		logic [31:0] writeback_count;
	} rsp_t;

	function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c,
			input logic [CntW-1:0] d);
		logic [CntW:0] s;
		s = {1'b0, c} + {1'b0, d};
		return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
	endfunction

endpackage

// File: hdl/set_assoc_cache_access_model_core.sv
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid/in_ready   | in_data  (req_t)
// out     | out | out_valid/out_ready | out_data (rsp_t)
// cfg     | in  | APB psel/penable    | pwdata[0] = policy (0 FIFO, 1 LRU)
// The back end takes one item at a time: set read, update and rewrite, result
// beat; the single-port set memory and per-set read-modify-write set this.
// After reset a clearing pass over all SETS sets initializes the set memory.
// A two-entry queue takes items while the back end works or the result stalls.
module set_assoc_cache_access_model_core import sacache_pkg::*; #(
	parameter int unsigned WAYS = WaysDefault,
	parameter int unsigned SETS = SetsDefault,
	parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic policy_q;
	logic q_valid, q_ready;
	req_t q_data;

	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == 2'(RegPolicy * 4)) ? {31'd0, policy_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == 2'(RegPolicy * 4)) begin
			policy_q <= pwdata[0];
		end
	end

	sacache_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.q_valid, .q_ready, .q_data
	);

	sacache_back #(.WAYS(WAYS), .SETS(SETS), .ADDR_BITS(ADDR_BITS)) u_back (
		.clk, .arst_n, .policy(policy_q), .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .out_data
	);

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_hit_refill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.refill))
		else $error("hit and refill together");
	a_wb_refill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.writeback |-> out_data.refill)
		else $error("writeback without refill");
`endif

endmodule

// File: hdl/sacache_front.sv
module sacache_front import sacache_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic q_valid,
	input  logic q_ready,
	output req_t q_data
);
	// two-entry queue between the front and the back
	req_t       mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: hdl/sacache_back.sv
module sacache_back import sacache_pkg::*; #(
	parameter int unsigned WAYS = WaysDefault,
	parameter int unsigned SETS = SetsDefault,
	parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic policy,
	input  logic q_valid,
	output logic q_ready,
	input  req_t q_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);
	localparam int unsigned SetW = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int unsigned SetBits = $clog2(SETS);
	localparam int unsigned TagW = (AW > SetBits) ? AW - SetBits : 1;
	localparam int unsigned DirtyW = $clog2(SETS * WAYS + 1);

	typedef struct packed {
		logic            valid;
		logic [TagW-1:0] tag;
		logic            dirty;
		logic [WayW-1:0] prio;
	} way_t;
	typedef way_t set_row_t [WAYS];

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_OUT} state_e;

	set_row_t        mem [SETS];
	set_row_t        rd_q;

	state_e          state_q;
	logic [SetW:0]   clr_q;
	req_t            req_q;
	logic [SetW-1:0] set_q;
	logic [CntW-1:0] cnt_q [CntNum];
	logic [DirtyW-1:0] dirty_q;
	logic            hit_q, refill_q, wb_q;
	logic [AW-1:0]   addr;
	logic [SetW-1:0] set_idx;

	assign addr = q_data.blk_addr[AW-1:0];
	always_comb begin
		if (SETS > 1) set_idx = SetW'(addr[SetW-1:0]);
		else set_idx = '0;
	end

	assign q_ready = (state_q == ST_IDLE);

	// hit, victim and next row
	logic [TagW-1:0] rtag;
	logic            h;
	logic [WayW-1:0] use_w, hit_w, inv_w, pz_w;
	logic            have_hit, have_inv, is_wr, op;
	logic            vict_dirty;
	set_row_t        nrow;
	logic            doprom;
	logic [WayW-1:0] oldp;

	assign rtag = TagW'(req_q.blk_addr[AW-1:0] >> SetBits);
	assign is_wr = (req_q.req_type == REQ_WRITE);
	assign op = (req_q.req_type == REQ_READ) || is_wr;

	always_comb begin
		have_hit = 1'b0; hit_w = '0; have_inv = 1'b0; inv_w = '0; pz_w = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (rd_q[i].valid && rd_q[i].tag == (AW > SetBits ? rtag : '0)) begin
				have_hit = 1'b1; hit_w = WayW'(i);
			end
			if (!rd_q[i].valid) begin
				have_inv = 1'b1; inv_w = WayW'(i);
			end
			if (rd_q[i].prio == '0) pz_w = WayW'(i);
		end
		h = have_hit;
		use_w = have_hit ? hit_w : (have_inv ? inv_w : pz_w);
		vict_dirty = !have_hit && !have_inv && rd_q[use_w].dirty;
		doprom = (!have_hit && policy == POL_FIFO) || (policy == POL_LRU);
		oldp = rd_q[use_w].prio;
		nrow = rd_q;
		if (!have_hit) begin
			nrow[use_w].valid = 1'b1;
			nrow[use_w].tag = rtag;
			nrow[use_w].dirty = 1'b0;
		end
		if (is_wr) nrow[use_w].dirty = 1'b1;
		if (doprom) begin
			for (int k = 0; k < WAYS; k++) begin
				if (rd_q[k].prio > oldp) nrow[k].prio = rd_q[k].prio - 1'b1;
			end
			nrow[use_w].prio = WayW'(WAYS - 1);
		end
	end

	logic newly_dirty;
	assign newly_dirty = is_wr && (have_hit ? !rd_q[use_w].dirty
	                                        : (vict_dirty || !rd_q[use_w].dirty));

	// set memory: clear in CLEAR, read in IDLE, rewrite in LOOK for reads and writes
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			rd_q <= mem[set_idx];
			req_q <= q_data;
			set_q <= set_idx;
		end
		if (state_q == ST_CLEAR) begin
			for (int i = 0; i < WAYS; i++) begin
				mem[clr_q[SetW-1:0]][i] <= '{valid: 1'b0, tag: '0, dirty: 1'b0,
					prio: WayW'(i)};
			end
		end else if (state_q == ST_LOOK && op) begin
			mem[set_q] <= nrow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			dirty_q <= '0;
			hit_q <= 1'b0; refill_q <= 1'b0; wb_q <= 1'b0;
			for (int i = 0; i < CntNum; i++) cnt_q[i] <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (SetW + 1)'(SETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (q_valid) begin
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					hit_q <= 1'b0; refill_q <= 1'b0; wb_q <= 1'b0;
					if (req_q.req_type == REQ_FLUSH) begin
						cnt_q[CntWb] <= sat_inc(cnt_q[CntWb], CntW'(dirty_q));
					end else if (op) begin
						hit_q <= h; refill_q <= !h; wb_q <= vict_dirty;
						cnt_q[CntAcc] <= sat_inc(cnt_q[CntAcc], 32'd1);
						if (is_wr) cnt_q[CntWr] <= sat_inc(cnt_q[CntWr], 32'd1);
						else cnt_q[CntRd] <= sat_inc(cnt_q[CntRd], 32'd1);
						if (h) cnt_q[CntHit] <= sat_inc(cnt_q[CntHit], 32'd1);
						else begin
							cnt_q[CntMiss] <= sat_inc(cnt_q[CntMiss], 32'd1);
							cnt_q[CntFetch] <= sat_inc(cnt_q[CntFetch], 32'd1);
						end
						if (vict_dirty) cnt_q[CntWb] <= sat_inc(cnt_q[CntWb], 32'd1);
						dirty_q <= dirty_q + DirtyW'(newly_dirty) - DirtyW'(vict_dirty);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign out_data = '{hit: hit_q, refill: refill_q, writeback: wb_q,
		access_count: cnt_q[CntAcc], read_count: cnt_q[CntRd],
		write_count: cnt_q[CntWr], hit_count: cnt_q[CntHit],
		miss_count: cnt_q[CntMiss], fetch_count: cnt_q[CntFetch],
		writeback_count: cnt_q[CntWb]};

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import sacache_pkg::*;

	localparam int unsigned NW = WaysDefault;
	localparam int unsigned NS = SetsDefault;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	req_t        in_data;
	logic        out_valid;
	logic        out_ready;
	rsp_t        out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned errors = 0;
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned n_sent = 0;
	int unsigned n_hits = 0;
	int unsigned n_wbs = 0;

	set_assoc_cache_access_model_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	class cache_scoreboard;
		logic        valid_q [NS][NW];
		logic [23:0] tag_q [NS][NW];
		logic        dirty_q [NS][NW];
		logic [1:0]  prio_q [NS][NW];
		logic [31:0] dirty_total;
		logic [31:0] ctr [CntNum];
		logic        lru;
		rsp_t        pending [$];

		function new();
			for (int s = 0; s < NS; s++)
				for (int w = 0; w < NW; w++) begin
					valid_q[s][w] = 0;
					tag_q[s][w] = 0;
					dirty_q[s][w] = 0;
					prio_q[s][w] = 2'(w);
				end
			dirty_total = 0;
			foreach (ctr[i]) ctr[i] = 0;
			lru = 0;
		endfunction

		function void bump(int i, logic [31:0] d);
			logic [32:0] s;
			s = {1'b0, ctr[i]} + {1'b0, d};
			ctr[i] = s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function void touch(int s, int w);
			logic [1:0] old;
			old = prio_q[s][w];
			for (int k = 0; k < NW; k++)
				if (prio_q[s][k] > old) prio_q[s][k]--;
			prio_q[s][w] = 2'(NW - 1);
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int s;
			int w;
			logic [23:0] t;
			logic wr;
			e = '0;
			s = r.blk_addr[7:0];
			t = r.blk_addr[31:8];
			wr = (r.req_type == REQ_WRITE);
			if (r.req_type == REQ_FLUSH) begin
				bump(CntWb, dirty_total);
			end else if (r.req_type == REQ_READ || r.req_type == REQ_WRITE) begin
				bump(wr ? CntWr : CntRd, 1);
				w = NW;
				for (int k = 0; k < NW; k++)
					if (w == NW && valid_q[s][k] && tag_q[s][k] == t) w = k;
				if (w < NW) begin
					e.hit = 1;
					bump(CntHit, 1);
					if (wr && !dirty_q[s][w]) begin
						dirty_q[s][w] = 1;
						dirty_total++;
					end
				end else begin
					for (int k = 0; k < NW; k++)
						if (w == NW && !valid_q[s][k]) w = k;
					if (w == NW) begin
						w = 0;
						for (int k = NW - 1; k >= 0; k--)
							if (prio_q[s][k] == 0) w = k;
						if (dirty_q[s][w]) begin
							e.writeback = 1;
							bump(CntWb, 1);
							dirty_q[s][w] = 0;
							dirty_total--;
						end
					end
					valid_q[s][w] = 1;
					tag_q[s][w] = t;
					if (wr && !dirty_q[s][w]) begin
						dirty_q[s][w] = 1;
						dirty_total++;
					end
					e.refill = 1;
					bump(CntMiss, 1);
					bump(CntFetch, 1);
					if (!lru) touch(s, w);
				end
				if (lru) touch(s, w);
				bump(CntAcc, 1);
			end
			e.access_count = ctr[CntAcc];
			e.read_count = ctr[CntRd];
			e.write_count = ctr[CntWr];
			e.hit_count = ctr[CntHit];
			e.miss_count = ctr[CntMiss];
			e.fetch_count = ctr[CntFetch];
			e.writeback_count = ctr[CntWb];
			pending.push_back(e);
		endfunction

		task check_response(rsp_t g);
			rsp_t e;
			if (pending.size() == 0) begin
				report_mismatch("unexpected beat", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (g.hit !== e.hit) report_mismatch("hit", 32'(g.hit), 32'(e.hit));
			if (g.refill !== e.refill)
				report_mismatch("refill", 32'(g.refill), 32'(e.refill));
			if (g.writeback !== e.writeback)
				report_mismatch("writeback", 32'(g.writeback), 32'(e.writeback));
			if (g.access_count !== e.access_count)
				report_mismatch("access_count", g.access_count, e.access_count);
			if (g.read_count !== e.read_count)
				report_mismatch("read_count", g.read_count, e.read_count);
			if (g.write_count !== e.write_count)
				report_mismatch("write_count", g.write_count, e.write_count);
			if (g.hit_count !== e.hit_count)
				report_mismatch("hit_count", g.hit_count, e.hit_count);
			if (g.miss_count !== e.miss_count)
				report_mismatch("miss_count", g.miss_count, e.miss_count);
			if (g.fetch_count !== e.fetch_count)
				report_mismatch("fetch_count", g.fetch_count, e.fetch_count);
			if (g.writeback_count !== e.writeback_count)
				report_mismatch("writeback_count", g.writeback_count, e.writeback_count);
		endtask
	endclass

	cache_scoreboard sb;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: random stall, check every accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (out_data.hit) n_hits++;
				if (out_data.writeback) n_wbs++;
				sb.check_response(out_data);
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// valid stays up after a beat until the next idle cycle or a drain
	task automatic send_request(input logic [1:0] rt, input logic [31:0] addr);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{req_type: rt, blk_addr: addr};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request('{req_type: rt, blk_addr: addr});
		n_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_policy(input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 2'(RegPolicy * 4);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.lru = v[0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (prdata !== {31'd0, v[0]})
			report_mismatch("policy readback", prdata, {31'd0, v[0]});
	endtask

	// mostly a few hot tags per set so hits and evictions both happen
	task automatic random_burst(input int n);
		logic [1:0]  rt;
		logic [31:0] a;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 3) rt = REQ_FLUSH;
			else if (r < 5) rt = REQ_NONE;
			else if (r < 50) rt = REQ_WRITE;
			else rt = REQ_READ;
			if ($urandom_range(9) < 8)
				a = {$urandom_range(7) ? 24'($urandom_range(5)) : 24'($urandom),
					8'($urandom_range(3))};
			else
				a = $urandom;
			send_request(rt, a);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_policy(32'h0);
		send_request(REQ_READ, 32'h0000_0000);
		send_request(REQ_READ, 32'h0000_0000);
		send_request(REQ_WRITE, 32'hFFFF_FFFF);
		send_request(REQ_FLUSH, 32'h0);
		send_request(REQ_NONE, 32'h1234_5678);
		// fill one set past its ways: dirty and clean victims
		for (int k = 0; k < 6; k++)
			send_request(k[0] ? REQ_READ : REQ_WRITE, {24'(k + 1), 8'h05});
		send_request(REQ_READ, {24'h3, 8'h05});
		send_request(REQ_FLUSH, 32'hAAAA_5555);
		send_request(REQ_WRITE, 32'h5555_AAAA);
		drain_results();
		write_policy(32'h1);
		for (int k = 0; k < 6; k++)
			send_request(REQ_WRITE, {24'(k % 5), 8'h07});
		send_request(REQ_READ, {24'h0, 8'h07});
		send_request(REQ_FLUSH, 32'hFFFF_FFFF);
		drain_results();

		send_idle = 17;
		recv_idle = 78;
		write_policy(32'h0);
		random_burst(100);
		drain_results();
		write_policy(32'h1);
		random_burst(100);
		drain_results();
		send_idle = 78;
		recv_idle = 17;
		random_burst(100);
		drain_results();
		write_policy(32'h0);
		random_burst(100);
		drain_results();
		send_idle = 0;
		recv_idle = 0;
		write_policy(32'hFFFF_FFFE);
		random_burst(100);
		drain_results();
		write_policy(32'hFFFF_FFFF);
		random_burst(100);
		drain_results();

		$display("sent %0d requests over both policies and three stall mixes", n_sent);
		$display("saw %0d hits and %0d dirty evictions", n_hits, n_wbs);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
